// ===== design/csc_pkg.sv =====
// Shared types, constants and helpers of the column substitution counter.
package csc_pkg;

    // Field widths fixed by the stream format
    localparam int BASE_W    = 3;
    localparam int MAX_SLOTS = 16;
    localparam int COLUMN_W  = BASE_W * MAX_SLOTS;
    localparam int MASK_W    = 16;
    localparam int SEL_W     = 6;
    localparam int READ_W    = 32;
    localparam int CFG_W     = 5;
    localparam int CMD_W     = 2;

    // Substitution matrix geometry: rows A,C,T,G; columns A,C,T,G,gap
    localparam int REF_ROWS     = 4;
    localparam int ROW_LEN      = REF_ROWS + 1;
    localparam int MATRIX_CELLS = REF_ROWS * ROW_LEN;
    localparam int CELL_W       = $clog2(MATRIX_CELLS);
    localparam int ROW_W        = $clog2(REF_ROWS);

    // Per-column increment: 0..MAX_SLOTS
    localparam int INC_W = $clog2(MAX_SLOTS + 1);

    // Base codes
    localparam logic [BASE_W-1:0] BASE_A   = 3'd0;
    localparam logic [BASE_W-1:0] BASE_C   = 3'd1;
    localparam logic [BASE_W-1:0] BASE_T   = 3'd2;
    localparam logic [BASE_W-1:0] BASE_G   = 3'd3;
    localparam logic [BASE_W-1:0] BASE_GAP = 3'd4;

    // Counter select map
    localparam logic [SEL_W-1:0] SEL_MEM_BASE = 6'd20;
    localparam logic [SEL_W-1:0] SEL_SITES    = 6'd40;
    localparam logic [SEL_W-1:0] SEL_ALL_DIFF = 6'd41;
    localparam logic [SEL_W-1:0] SEL_MEM_DIFF = 6'd42;
    localparam logic [SEL_W-1:0] SEL_PRESENCE = 6'd43;

    // Register reset values
    localparam logic [CFG_W-1:0] REF_SLOT_RESET = 5'd16;
    localparam logic [CFG_W-1:0] IN_USE_RESET   = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_PROCESS = 2'd0,
        CMD_READ    = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic {
        CFG_REFERENCE_SLOT = 1'b0,
        CFG_SPECIES_IN_USE = 1'b1
    } cfg_reg_t;

    // Column classification handed to the counter bank
    typedef struct packed {
        logic             site;          // column counts as a site
        logic             all_differ;    // some taking species differs
        logic             member_differ; // some taking member differs
        logic             matrix_ok;     // reference is A,C,T or G
        logic [ROW_W-1:0] ref_row;       // matrix row of the reference
    } csc_update_t;

    // Population count of a slot vector, as four nibble counts summed
    function automatic logic [INC_W-1:0] count_ones(input logic [MAX_SLOTS-1:0] v);
        logic [2:0]       grp [4];
        logic [INC_W-1:0] total;
        total = '0;
        for (int g = 0; g < 4; g++) begin
            grp[g] = '0;
            for (int k = 0; k < 4; k++) begin
                grp[g] = grp[g] + 3'(v[4*g+k]);
            end
            total = total + INC_W'(grp[g]);
        end
        return total;
    endfunction

endpackage

// ===== design/csc_classify.sv =====
// Column classifier: reference pick, per-species compare and per-cell tallies.
module csc_classify #(
    parameter int MAX_SPECIES = 16
) (
    input  logic [csc_pkg::CFG_W-1:0]    ref_slot_cfg,
    input  logic [csc_pkg::CFG_W-1:0]    in_use_cfg,
    input  logic [csc_pkg::COLUMN_W-1:0] bases,
    input  logic [csc_pkg::MASK_W-1:0]   mask,
    input  logic [csc_pkg::BASE_W-1:0]   ext_ref,
    output csc_pkg::csc_update_t         upd,
    output logic [csc_pkg::INC_W-1:0]    all_cnt [csc_pkg::ROW_LEN],
    output logic [csc_pkg::INC_W-1:0]    mem_cnt [csc_pkg::ROW_LEN],
    output logic [MAX_SPECIES-1:0]       presence_inc
);
    import csc_pkg::*;

    localparam int SLOT_W = (MAX_SPECIES > 1) ? $clog2(MAX_SPECIES) : 1;

    logic              external;
    logic              col_valid;
    logic [SLOT_W-1:0] rs;
    logic [CFG_W-1:0]  n_used;
    logic [BASE_W-1:0] ref_base;
    logic [MAX_SPECIES-1:0] takes;
    logic [MAX_SPECIES-1:0] differs;
    logic [MAX_SPECIES-1:0] is_member;
    logic [MAX_SLOTS-1:0]   all_hit [ROW_LEN];
    logic [MAX_SLOTS-1:0]   mem_hit [ROW_LEN];
    logic any_all;
    logic any_mem;

    assign external = (ref_slot_cfg >= CFG_W'(MAX_SPECIES));
    assign rs       = ref_slot_cfg[SLOT_W-1:0];
    assign n_used   = (in_use_cfg > CFG_W'(MAX_SPECIES)) ? CFG_W'(MAX_SPECIES) : in_use_cfg;
    assign ref_base = external ? ext_ref : bases[BASE_W*rs +: BASE_W];
    // a slot reference only counts the column when that slot shares the site
    assign col_valid = external || mask[rs];

    always_comb begin
        for (int j = 0; j < MAX_SPECIES; j++) begin
            takes[j]     = (CFG_W'(j) < n_used) && (external || CFG_W'(j) != ref_slot_cfg);
            // unknown codes always differ, even against an equal reference code
            differs[j]   = (bases[BASE_W*j +: BASE_W] != ref_base)
                           || (bases[BASE_W*j +: BASE_W] > BASE_GAP);
            is_member[j] = mask[j];
        end
    end

    assign any_all = |(takes & differs);
    assign any_mem = |(takes & differs & is_member);

    always_comb begin
        for (int c = 0; c < ROW_LEN; c++) begin
            all_hit[c] = '0;
            mem_hit[c] = '0;
            for (int j = 0; j < MAX_SPECIES; j++) begin
                all_hit[c][j] = takes[j] && (bases[BASE_W*j +: BASE_W] == BASE_W'(c));
                mem_hit[c][j] = all_hit[c][j] && is_member[j];
            end
            all_cnt[c] = count_ones(all_hit[c]);
            mem_cnt[c] = count_ones(mem_hit[c]);
        end
    end

    assign presence_inc = takes & is_member & {MAX_SPECIES{col_valid}};

    always_comb begin
        upd.site          = col_valid;
        upd.all_differ    = col_valid && any_all;
        upd.member_differ = col_valid && any_mem;
        upd.matrix_ok     = (ref_base < BASE_W'(REF_ROWS));
        upd.ref_row       = ref_base[ROW_W-1:0];
    end

endmodule

// ===== design/csc_counters.sv =====
// Saturating counter bank: both matrices, column totals, presence, read select.
module csc_counters #(
    parameter int MAX_SPECIES = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       proc_en,
    input  logic                       clr_en,
    input  csc_pkg::csc_update_t       upd,
    input  logic [csc_pkg::INC_W-1:0]  all_cnt [csc_pkg::ROW_LEN],
    input  logic [csc_pkg::INC_W-1:0]  mem_cnt [csc_pkg::ROW_LEN],
    input  logic [MAX_SPECIES-1:0]     presence_inc,
    input  logic [csc_pkg::SEL_W-1:0]  rd_sel,
    output logic [COUNT_WIDTH-1:0]     rd_value
);
    import csc_pkg::*;

    localparam int SLOT_W = (MAX_SPECIES > 1) ? $clog2(MAX_SPECIES) : 1;

    logic [COUNT_WIDTH-1:0] all_mat_reg  [MATRIX_CELLS];
    logic [COUNT_WIDTH-1:0] mem_mat_reg  [MATRIX_CELLS];
    logic [COUNT_WIDTH-1:0] presence_reg [MAX_SPECIES];
    logic [COUNT_WIDTH-1:0] sites_reg;
    logic [COUNT_WIDTH-1:0] all_diff_reg;
    logic [COUNT_WIDTH-1:0] mem_diff_reg;

    logic             all_row_en;
    logic             mem_row_en;
    logic [SEL_W-1:0] mem_off;
    logic [SEL_W-1:0] pres_off;

    function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] c,
                                                       input logic [INC_W-1:0] inc);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, c} + (COUNT_WIDTH+1)'(inc);
        return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    endfunction

    assign all_row_en = upd.all_differ && upd.matrix_ok;
    assign mem_row_en = upd.member_differ && upd.matrix_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn || clr_en) begin
            for (int i = 0; i < MATRIX_CELLS; i++) begin
                all_mat_reg[i] <= '0;
                mem_mat_reg[i] <= '0;
            end
            for (int j = 0; j < MAX_SPECIES; j++) begin
                presence_reg[j] <= '0;
            end
            sites_reg    <= '0;
            all_diff_reg <= '0;
            mem_diff_reg <= '0;
        end else if (proc_en) begin
            // only the reference row moves; each cell takes its column tally
            for (int r = 0; r < REF_ROWS; r++) begin
                for (int c = 0; c < ROW_LEN; c++) begin
                    if (all_row_en && upd.ref_row == ROW_W'(r)) begin
                        all_mat_reg[r*ROW_LEN+c] <= sat_add(all_mat_reg[r*ROW_LEN+c], all_cnt[c]);
                    end
                    if (mem_row_en && upd.ref_row == ROW_W'(r)) begin
                        mem_mat_reg[r*ROW_LEN+c] <= sat_add(mem_mat_reg[r*ROW_LEN+c], mem_cnt[c]);
                    end
                end
            end
            for (int j = 0; j < MAX_SPECIES; j++) begin
                presence_reg[j] <= sat_add(presence_reg[j], INC_W'(presence_inc[j]));
            end
            sites_reg    <= sat_add(sites_reg, INC_W'(upd.site));
            all_diff_reg <= sat_add(all_diff_reg, INC_W'(upd.all_differ));
            mem_diff_reg <= sat_add(mem_diff_reg, INC_W'(upd.member_differ));
        end
    end

    assign mem_off  = rd_sel - SEL_MEM_BASE;
    assign pres_off = rd_sel - SEL_PRESENCE;

    always_comb begin
        rd_value = '0;
        priority if (rd_sel < SEL_MEM_BASE) begin
            rd_value = all_mat_reg[rd_sel[CELL_W-1:0]];
        end else if (rd_sel < SEL_SITES) begin
            rd_value = mem_mat_reg[mem_off[CELL_W-1:0]];
        end else if (rd_sel == SEL_SITES) begin
            rd_value = sites_reg;
        end else if (rd_sel == SEL_ALL_DIFF) begin
            rd_value = all_diff_reg;
        end else if (rd_sel == SEL_MEM_DIFF) begin
            rd_value = mem_diff_reg;
        end else if (pres_off < SEL_W'(MAX_SPECIES)) begin
            rd_value = presence_reg[pres_off[SLOT_W-1:0]];
        end else begin
            rd_value = '0;
        end
    end

endmodule

// ===== design/column_substitution_counter.sv =====
// Top level of the column substitution counter: stream ports, registers, pipeline.
//
// Takes one alignment column, counter read, counter clear or spare command per
// transfer and returns one result transfer for each. A column is captured in the
// input register, classified against its reference (external base or a configured
// species slot) and applied to the saturating counter bank on the edge where the
// result register loads; a new transfer is accepted every cycle while the result
// side is not stalled, so the sustained rate is one item per clock. Each item
// passes through the input register and then the result register. The counter
// update (per-cell tally of up to 16 species plus a saturating add) sets the
// clock. Reads see every earlier column. Configuration is written through
// cfg_wr_en/cfg_index/cfg_wr_data while no transfer is in flight.
module column_substitution_counter #(
    parameter int MAX_SPECIES = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,      // 0 reference_slot, 1 species_in_use
    input  logic [4:0]  cfg_wr_data,
    // column / command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // column_bases[47:0], member_mask[63:48],
                                        // external_reference[66:64],
                                        // counter_select[72:67], zero pad
    input  logic [1:0]  s_axis_tuser,   // cmd
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // read_value[31:0], site_counted[32],
                                        // all_differ[33], member_differ[34], zero pad
);
    import csc_pkg::*;

    // configuration
    logic [CFG_W-1:0] ref_slot_reg;
    logic [CFG_W-1:0] in_use_reg;

    // input register
    logic                in_valid_reg;
    logic                in_valid_next;
    cmd_t                in_cmd_reg;
    logic [COLUMN_W-1:0] in_bases_reg;
    logic [MASK_W-1:0]   in_mask_reg;
    logic [BASE_W-1:0]   in_ext_reg;
    logic [SEL_W-1:0]    in_sel_reg;

    // result register
    logic                out_valid_reg;
    logic [READ_W-1:0]   out_read_reg;
    logic                out_site_reg;
    logic                out_all_reg;
    logic                out_mem_reg;

    logic advance;
    logic s_xfer;
    logic step;
    logic proc_en;
    logic clr_en;

    csc_update_t            upd;
    logic [INC_W-1:0]       all_cnt [ROW_LEN];
    logic [INC_W-1:0]       mem_cnt [ROW_LEN];
    logic [MAX_SPECIES-1:0] presence_inc;
    logic [COUNT_WIDTH-1:0] rd_value;

    // result register frees up when empty or being taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    // the held item moves into the result register on this edge
    assign step          = in_valid_reg && advance;
    assign proc_en       = step && (in_cmd_reg == CMD_PROCESS);
    assign clr_en        = step && (in_cmd_reg == CMD_CLEAR);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_slot_reg <= REF_SLOT_RESET;
            in_use_reg   <= IN_USE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_REFERENCE_SLOT: ref_slot_reg <= cfg_wr_data;
                CFG_SPECIES_IN_USE: in_use_reg   <= cfg_wr_data;
                default:            ref_slot_reg <= ref_slot_reg;
            endcase
        end
    end

    // input register
    always_comb begin
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_cmd_reg   <= cmd_t'(s_axis_tuser);
            in_bases_reg <= s_axis_tdata[COLUMN_W-1:0];
            in_mask_reg  <= s_axis_tdata[COLUMN_W +: MASK_W];
            in_ext_reg   <= s_axis_tdata[COLUMN_W+MASK_W +: BASE_W];
            in_sel_reg   <= s_axis_tdata[COLUMN_W+MASK_W+BASE_W +: SEL_W];
        end
    end

    csc_classify #(
        .MAX_SPECIES (MAX_SPECIES)
    ) u_classify (
        .ref_slot_cfg (ref_slot_reg),
        .in_use_cfg   (in_use_reg),
        .bases        (in_bases_reg),
        .mask         (in_mask_reg),
        .ext_ref      (in_ext_reg),
        .upd          (upd),
        .all_cnt      (all_cnt),
        .mem_cnt      (mem_cnt),
        .presence_inc (presence_inc)
    );

    csc_counters #(
        .MAX_SPECIES (MAX_SPECIES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counters (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .proc_en      (proc_en),
        .clr_en       (clr_en),
        .upd          (upd),
        .all_cnt      (all_cnt),
        .mem_cnt      (mem_cnt),
        .presence_inc (presence_inc),
        .rd_sel       (in_sel_reg),
        .rd_value     (rd_value)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_read_reg <= (in_cmd_reg == CMD_READ) ? READ_W'(rd_value) : '0;
            out_site_reg <= (in_cmd_reg == CMD_PROCESS) && upd.site;
            out_all_reg  <= (in_cmd_reg == CMD_PROCESS) && upd.all_differ;
            out_mem_reg  <= (in_cmd_reg == CMD_PROCESS) && upd.member_differ;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_mem_reg, out_all_reg, out_site_reg, out_read_reg};

    // an ignored column or a non-process command raises no difference flag
    a_flags_need_site: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[32] |-> !m_axis_tdata[33] && !m_axis_tdata[34])
        else $error("difference flag without a counted site");

    // a differing member is also a differing species
    a_member_in_all: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[34] |-> m_axis_tdata[33])
        else $error("member_differ set without all_differ");

    // read data and column flags never come from the same item
    a_read_no_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[31:0] != '0) |-> !m_axis_tdata[32])
        else $error("read value on a processed column");

    // a held item is not dropped while the result side stalls
    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending item lost during stall");

endmodule

// ===== bench/column_substitution_counter_tb.sv =====
// Self-checking testbench for the column substitution counter.
`timescale 1ns / 100ps

module column_substitution_counter_tb;
    import csc_pkg::*;

    // Run guard: ~1250 items, each at worst a maximal send gap, a maximal
    // result stall and the pipeline, plus the long hold-off; the limit
    // leaves ample margin over that total.
    localparam int CYCLE_LIMIT = 400_000;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE      = 8;   // extra wait after the last expected result has arrived

    // One result transfer as seen on m_axis_tdata (first member is the top bit)
    typedef struct packed {
        logic              member_differ;
        logic              all_differ;
        logic              site_counted;
        logic [READ_W-1:0] read_value;
    } column_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [4:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // column_bases[47:0], member_mask[63:48],
                                 // external_reference[66:64], counter_select[72:67]
    logic [1:0]  s_axis_tuser;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // read_value[31:0], site_counted[32],
                                 // all_differ[33], member_differ[34]

    column_substitution_counter i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and counter bank
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  ref_slot_cfg;
    logic [CFG_W-1:0]  in_use_cfg;
    logic [READ_W-1:0] all_tally    [MATRIX_CELLS];
    logic [READ_W-1:0] member_tally [MATRIX_CELLS];
    logic [READ_W-1:0] presence     [MAX_SLOTS];
    logic [READ_W-1:0] site_total;
    logic [READ_W-1:0] all_diff_total;
    logic [READ_W-1:0] member_diff_total;

    column_result_t expected_results [$];

    // Stimulus control and bookkeeping
    logic idle_on;       // random idling on both sides
    logic hold_req;      // ask the result sink for one long hold-off
    int   error_count;
    int   result_count;
    int   cycle_count;
    int   input_stall_cycles;
    int   columns_sent, reads_sent, clears_sent, nops_sent;
    int   settings_applied;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [READ_W-1:0] sat_inc(input logic [READ_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void clear_tallies();
        for (int i = 0; i < MATRIX_CELLS; i++) begin
            all_tally[i]    = '0;
            member_tally[i] = '0;
        end
        for (int k = 0; k < MAX_SLOTS; k++) presence[k] = '0;
        site_total        = '0;
        all_diff_total    = '0;
        member_diff_total = '0;
    endfunction

    // Expected result of one accepted transfer; updates the counter copy.
    function automatic column_result_t predict_transfer(
        input cmd_t              c,
        input logic [COLUMN_W-1:0] bases,
        input logic [MASK_W-1:0] mask,
        input logic [BASE_W-1:0] ext,
        input logic [SEL_W-1:0]  sel
    );
        column_result_t        r;
        logic                  external, any_all, any_mem;
        logic [BASE_W-1:0]     ref_base, b;
        logic [MAX_SLOTS-1:0]  takes;
        int                    n, cell_idx;
        r = '0;
        case (c)
            CMD_READ: begin
                if (sel < MATRIX_CELLS)           r.read_value = all_tally[sel];
                else if (sel < SEL_SITES)         r.read_value = member_tally[sel - SEL_MEM_BASE];
                else if (sel == SEL_SITES)        r.read_value = site_total;
                else if (sel == SEL_ALL_DIFF)     r.read_value = all_diff_total;
                else if (sel == SEL_MEM_DIFF)     r.read_value = member_diff_total;
                else if (sel < SEL_PRESENCE + MAX_SLOTS)
                    r.read_value = presence[sel - SEL_PRESENCE];
            end
            CMD_CLEAR: clear_tallies();
            CMD_PROCESS: begin
                external = (ref_slot_cfg >= MAX_SLOTS);
                // internal reference that is not a member: column dropped
                if (external || mask[ref_slot_cfg[3:0]]) begin
                    n = (in_use_cfg > MAX_SLOTS) ? MAX_SLOTS : int'(in_use_cfg);
                    ref_base = external ? ext : bases[BASE_W*ref_slot_cfg[3:0] +: BASE_W];
                    site_total = sat_inc(site_total);
                    any_all = 1'b0;
                    any_mem = 1'b0;
                    for (int j = 0; j < MAX_SLOTS; j++) begin
                        b = bases[BASE_W*j +: BASE_W];
                        takes[j] = (j < n) && (external || j != ref_slot_cfg);
                        // unknown bases always differ, even against an equal code
                        if (takes[j] && (b != ref_base || b > BASE_GAP)) begin
                            any_all = 1'b1;
                            if (mask[j]) any_mem = 1'b1;
                        end
                    end
                    if (any_all) all_diff_total = sat_inc(all_diff_total);
                    if (any_mem) member_diff_total = sat_inc(member_diff_total);
                    for (int j = 0; j < MAX_SLOTS; j++) begin
                        b = bases[BASE_W*j +: BASE_W];
                        // gap/unknown reference or unknown base: no matrix cell
                        if (takes[j] && ref_base < REF_ROWS && b <= BASE_GAP) begin
                            cell_idx = ref_base * ROW_LEN + b;
                            if (any_all) all_tally[cell_idx] = sat_inc(all_tally[cell_idx]);
                            if (any_mem && mask[j])
                                member_tally[cell_idx] = sat_inc(member_tally[cell_idx]);
                        end
                        if (takes[j] && mask[j]) presence[j] = sat_inc(presence[j]);
                    end
                    r.site_counted  = 1'b1;
                    r.all_differ    = any_all;
                    r.member_differ = any_mem;
                end
            end
            default: ;  // spare command: no effect
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req      = 1'b0;
                m_axis_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 15) == 0) begin
                stall_left    = $urandom_range(1, 18) - 1;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each transfer against the oldest expectation
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [READ_W-1:0] got,
                                   input logic [READ_W-1:0] want);
        $display("[%0t] mismatch on result %0d, %s: got %0h, expected %0h",
                 $realtime, result_count, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin : result_check
        column_result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[34:0];
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transfer", got.read_value, '0);
            end else begin
                want = expected_results.pop_front();
                if (got.read_value !== want.read_value)
                    report_mismatch("read_value", got.read_value, want.read_value);
                if (got.site_counted !== want.site_counted)
                    report_mismatch("site_counted", READ_W'(got.site_counted),
                                    READ_W'(want.site_counted));
                if (got.all_differ !== want.all_differ)
                    report_mismatch("all_differ", READ_W'(got.all_differ),
                                    READ_W'(want.all_differ));
                if (got.member_differ !== want.member_differ)
                    report_mismatch("member_differ", READ_W'(got.member_differ),
                                    READ_W'(want.member_differ));
            end
            result_count++;
        end
    end

    // Cycle guard and input backpressure count
    always @(posedge aclk) begin
        cycle_count++;
        if (s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_count, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one item; returns at the edge where it was taken.
    task automatic send_item(input cmd_t c, input logic [COLUMN_W-1:0] bases,
                             input logic [MASK_W-1:0] mask, input logic [BASE_W-1:0] ext,
                             input logic [SEL_W-1:0] sel);
        int gap;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = c;
        s_axis_tdata  = {7'd0, sel, ext, mask, bases};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_results.push_back(predict_transfer(c, bases, mask, ext, sel));
        case (c)
            CMD_PROCESS: columns_sent++;
            CMD_READ:    reads_sent++;
            CMD_CLEAR:   clears_sent++;
            default:     nops_sent++;
        endcase
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_results_done();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == CFG_REFERENCE_SLOT) ref_slot_cfg = val;
        else                           in_use_cfg   = val;
    endtask

    // Registers change only with the pipeline empty
    task automatic set_config(input logic [CFG_W-1:0] slot, input logic [CFG_W-1:0] used);
        stop_sending();
        wait_results_done();
        write_reg(CFG_REFERENCE_SLOT, slot);
        write_reg(CFG_SPECIES_IN_USE, used);
        settings_applied++;
    endtask

    // Mostly columns dominated by one base, with random deviations
    task automatic send_random_item();
        cmd_t                c;
        logic [COLUMN_W-1:0] bases;
        logic [MASK_W-1:0]   mask;
        logic [BASE_W-1:0]   ext, lead;
        logic [SEL_W-1:0]    sel;
        int                  pick, style;
        pick  = $urandom_range(0, 99);
        bases = {16'($urandom), $urandom};
        mask  = 16'($urandom);
        ext   = 3'($urandom);
        sel   = 6'($urandom);
        if (pick < 2) begin
            c = CMD_CLEAR;
        end else if (pick < 5) begin
            c = CMD_NOP;
        end else if (pick < 25) begin
            c = CMD_READ;
            if ($urandom_range(0, 9) != 0) sel = 6'($urandom_range(0, 58));
        end else begin
            c = CMD_PROCESS;
            if (pick < 90) begin
                lead  = 3'($urandom_range(0, 3));
                style = $urandom_range(0, 4);
                for (int k = 0; k < MAX_SLOTS; k++) begin
                    if (style == 0 || $urandom_range(0, 3) != 0)
                        bases[BASE_W*k +: BASE_W] = lead;
                    else if ($urandom_range(0, 1) == 0)
                        bases[BASE_W*k +: BASE_W] = 3'($urandom_range(0, 4));
                end
                ext = ($urandom_range(0, 7) == 0) ? 3'($urandom) : lead;
                case ($urandom_range(0, 2))
                    0: mask = '1;
                    1: mask = ~(16'h1 << $urandom_range(0, 15));
                    default: ;
                endcase
                if (ref_slot_cfg < MAX_SLOTS && $urandom_range(0, 4) != 0)
                    mask[ref_slot_cfg[3:0]] = 1'b1;
            end
        end
        send_item(c, bases, mask, ext, sel);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        send_item(CMD_READ, '0, '0, BASE_A, '0);
        send_item(CMD_READ, '0, '0, BASE_A, SEL_SITES);
        send_item(CMD_READ, '0, '0, BASE_A, '1);
    endtask

    // External reference: uniform, mixed, all-unknown, gap and unknown reference
    task automatic test_external_reference();
        send_item(CMD_PROCESS, {MAX_SLOTS{BASE_A}}, '1, BASE_A, '0);
        send_item(CMD_PROCESS, {4{BASE_GAP, BASE_G, BASE_T, BASE_C}}, 16'hA5A5, BASE_A, '0);
        send_item(CMD_PROCESS, '1, '1, '1, '1);
        send_item(CMD_PROCESS, {{8{BASE_GAP}}, {8{BASE_T}}}, 16'h0F0F, BASE_GAP, '0);
        send_item(CMD_PROCESS, {MAX_SLOTS{3'd5}}, '1, 3'd5, '0);
    endtask

    task automatic test_reads_and_clear();
        send_item(CMD_NOP, '1, '1, '1, SEL_SITES);
        send_item(CMD_READ, '0, '0, BASE_A, 6'd4);
        send_item(CMD_READ, '0, '0, BASE_A, SEL_MEM_BASE);
        send_item(CMD_READ, '0, '0, BASE_A, SEL_SITES);
        send_item(CMD_READ, '0, '0, BASE_A, SEL_ALL_DIFF);
        send_item(CMD_READ, '0, '0, BASE_A, SEL_MEM_DIFF);
        send_item(CMD_READ, '0, '0, BASE_A, SEL_PRESENCE);
        send_item(CMD_READ, '0, '0, BASE_A, SEL_PRESENCE + 6'(MAX_SLOTS - 1));
        send_item(CMD_READ, '0, '0, BASE_A, SEL_PRESENCE + 6'(MAX_SLOTS));
        send_item(CMD_CLEAR, '0, '0, BASE_A, '0);
        send_item(CMD_READ, '0, '0, BASE_A, SEL_SITES);
    endtask

    // Slot reference (member or not), zero and oversize slot counts
    task automatic test_slot_reference();
        set_config(5'd0, 5'd16);
        send_item(CMD_PROCESS, {MAX_SLOTS{BASE_C}}, 16'hFFFE, BASE_A, '0);
        send_item(CMD_PROCESS, {{5{BASE_C, BASE_T, BASE_G}}, BASE_T}, '1, BASE_A, '0);
        set_config(5'd15, 5'd4);
        send_item(CMD_PROCESS, {{12{BASE_GAP}}, BASE_A, BASE_C, BASE_A, BASE_A}, '1, BASE_G, '0);
        set_config(5'd16, 5'd0);
        send_item(CMD_PROCESS, {4{BASE_GAP, BASE_G, BASE_T, BASE_C}}, '1, BASE_A, '0);
        set_config(5'd31, 5'd31);
        send_item(CMD_PROCESS, {4{BASE_GAP, BASE_G, BASE_T, BASE_C}}, '1, BASE_T, '0);
    endtask

    // Random items over a series of register settings, extremes included
    task automatic test_random_columns();
        logic [CFG_W-1:0] slot_pick [10] = '{16, 0, 15, 16, 7, 0, 16, 3, 15, 16};
        logic [CFG_W-1:0] used_pick [10] = '{16, 16, 16, 1, 9, 1, 5, 16, 12, 16};
        for (int p = 0; p < 10; p++) begin
            if (p == 9) set_config(5'($urandom_range(0, 16)), 5'($urandom_range(1, 16)));
            else        set_config(slot_pick[p], used_pick[p]);
            repeat (105) send_random_item();
        end
    endtask

    // Sink holds off for a long stretch while the source keeps offering
    task automatic test_backpressure();
        set_config(5'd16, 5'd16);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_random_item();
        idle_on = 1'b1;
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_full_rate();
        set_config(5'($urandom_range(0, 16)), 5'd16);
        idle_on = 1'b0;
        repeat (120) send_random_item();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_REFERENCE_SLOT;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_PROCESS;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        error_count   = 0;
        result_count  = 0;
        cycle_count   = 0;
        input_stall_cycles = 0;
        columns_sent  = 0;
        reads_sent    = 0;
        clears_sent   = 0;
        nops_sent     = 0;
        settings_applied = 0;
        ref_slot_cfg  = REF_SLOT_RESET;
        in_use_cfg    = IN_USE_RESET;
        clear_tallies();

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_external_reference();
        test_reads_and_clear();
        test_slot_reference();
        test_random_columns();
        test_backpressure();
        test_full_rate();

        stop_sending();
        wait_results_done();

        $display("Covered %0d columns, %0d reads, %0d clears, %0d spare commands",
                 columns_sent, reads_sent, clears_sent, nops_sent);
        $display("over %0d register settings; %0d results checked, input stalled %0d cycles",
                 settings_applied, result_count, input_stall_cycles);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
